/* rtl/css_pkg.sv */
// Package for the streaming cosine similarity block.
// Holds datapath widths, state codes and the controller/datapath command and status structs.
package css_pkg;

  localparam int unsigned SumWidth  = 48;
  localparam int unsigned ProdWidth = 96;
  localparam int unsigned RootWidth = 48;
  localparam int unsigned QuotWidth = 64;
  localparam int unsigned CosWidth  = 16;

  // Controller states, one-hot.
  typedef enum logic [5:0] {
    StIdle = 6'b000001,
    StMul  = 6'b000010,
    StSqrt = 6'b000100,
    StDiv  = 6'b001000,
    StSat  = 6'b010000,
    StOut  = 6'b100000
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accum;     // add the accepted pair into the sums
    logic latch;     // move sums to the finish stage and clear them
    logic mul_step;  // one partial product step of normA*normB
    logic sqrt_init;
    logic sqrt_step;
    logic div_init;
    logic div_step;
    logic sat;       // form the saturated result
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic zero_norm;
    logic mul_done;
    logic sqrt_done;
    logic div_done;
  } dp_sts_t;

endpackage

/* rtl/css_stream_if.sv */
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
interface css_stream_if #(
  parameter int unsigned Width = 1
);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/cosine_similarity_stream.sv */
// Top level of the streaming cosine similarity block.
// Depends on css_pkg, css_stream_if, css_ctrl and css_datapath.
//
// Element pairs are accepted one per cycle while no finish is in progress
// and summed exactly. The item marked last starts a finish sequence: the
// multiply state (three 16-bit partial-product steps for normA*normB, then
// a check that they are done), the square root (24 two-bit steps), the
// bit-serial divider (63 steps) and saturation. The result then waits on
// the output channel. No input item is taken from the last item of a
// vector until its result has been taken. A zero norm skips the multiply,
// root and divide: the multiply state sees it, forms the saturated result
// and passes straight to the output state.
module cosine_similarity_stream #(
  parameter int unsigned MaxDim    = 65536,
  parameter int unsigned ElemWidth = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  css_stream_if.sink   in_if,
  css_stream_if.source out_if
);
  import css_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic signed [CosWidth-1:0] cosine;
  logic                       zero_norm, overflow;

  css_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_last_i   (in_if.data[32]),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  css_datapath #(
    .MaxDim    (MaxDim),
    .ElemWidth (ElemWidth)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .a_elem_i    (in_if.data[15:0]),
    .b_elem_i    (in_if.data[31:16]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cosine_o    (cosine),
    .zero_norm_o (zero_norm),
    .overflow_o  (overflow)
  );

  // Output payload: cosine, zero_norm, overflow from low bits up.
  assign out_if.data = {overflow, zero_norm, cosine};

  // No item is taken while a result is pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_if.ready && out_if.valid))
    else $error("input accepted while result pending");

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && !out_if.ready) |=> $stable(out_if.data))
    else $error("result changed while stalled");

  // A zero-norm result carries cosine 0.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && zero_norm) |-> (cosine == '0))
    else $error("zero norm with nonzero cosine");

endmodule

/* rtl/css_ctrl.sv */
// Controller state machine for the cosine similarity block.
// Depends on css_pkg.
module css_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_last_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output css_pkg::dp_cmd_t cmd_o,
  input  css_pkg::dp_sts_t sts_i
);
  import css_pkg::*;

  state_e state_q, state_d;
  logic   in_fire;

  // Inputs stream while no finish is in progress.
  assign in_ready_o  = (state_q == StIdle);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == StOut);

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        cmd_o.accum = in_fire;
        if (in_fire && in_last_i) begin
          cmd_o.latch = 1'b1;
          state_d     = StMul;
        end
      end
      StMul: begin
        if (sts_i.zero_norm) begin
          cmd_o.sat = 1'b1;
          state_d   = StOut;
        end else if (sts_i.mul_done) begin
          cmd_o.sqrt_init = 1'b1;
          state_d         = StSqrt;
        end else begin
          cmd_o.mul_step = 1'b1;
        end
      end
      StSqrt: begin
        if (sts_i.sqrt_done) begin
          cmd_o.div_init = 1'b1;
          state_d        = StDiv;
        end else begin
          cmd_o.sqrt_step = 1'b1;
        end
      end
      StDiv: begin
        if (sts_i.div_done) begin
          state_d = StSat;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      StSat: begin
        cmd_o.sat = 1'b1;
        state_d   = StOut;
      end
      StOut: begin
        if (out_ready_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/css_datapath.sv */
// Datapath: running sums, partial-product multiplier, bit-serial root and divider.
// Depends on css_pkg.
module css_datapath #(
  parameter int unsigned MaxDim    = 65536,
  parameter int unsigned ElemWidth = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic signed [15:0]                a_elem_i,
  input  logic signed [15:0]                b_elem_i,
  input  css_pkg::dp_cmd_t                  cmd_i,
  output css_pkg::dp_sts_t                  sts_o,
  output logic signed [css_pkg::CosWidth-1:0] cosine_o,
  output logic                              zero_norm_o,
  output logic                              overflow_o
);
  import css_pkg::*;

  localparam int unsigned CntWidth = $clog2(MaxDim + 2);
  localparam logic [CntWidth-1:0] CntMax  = CntWidth'(MaxDim);
  localparam logic [CntWidth-1:0] CntOver = CntWidth'(MaxDim + 1);

  // Elements sign-extended from their low ElemWidth bits.
  logic signed [ElemWidth-1:0]   a_n, b_n;
  logic signed [2*ElemWidth-1:0] p_ab, p_aa, p_bb;
  assign a_n  = a_elem_i[ElemWidth-1:0];
  assign b_n  = b_elem_i[ElemWidth-1:0];
  assign p_ab = a_n * b_n;
  assign p_aa = a_n * a_n;
  assign p_bb = b_n * b_n;

  logic signed [SumWidth-1:0] dot_q;
  logic [SumWidth-1:0]        na_q, nb_q;
  logic [CntWidth-1:0]        cnt_q;

  // Running sums; pairs past MaxDim only mark overflow.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q <= '0;
      na_q  <= '0;
      nb_q  <= '0;
      cnt_q <= '0;
    end else if (cmd_i.latch) begin
      dot_q <= '0;
      na_q  <= '0;
      nb_q  <= '0;
      cnt_q <= '0;
    end else if (cmd_i.accum) begin
      if (cnt_q < CntMax) begin
        dot_q <= dot_q + SumWidth'(p_ab);
        na_q  <= na_q + SumWidth'($unsigned(p_aa));
        nb_q  <= nb_q + SumWidth'($unsigned(p_bb));
        cnt_q <= cnt_q + 1'b1;
      end else begin
        cnt_q <= CntOver;
      end
    end
  end

  // Values that include the final pair, taken on latch.
  logic signed [SumWidth-1:0] dot_fin;
  logic [SumWidth-1:0]        na_fin, nb_fin;
  logic                       ovf_fin;
  always_comb begin
    dot_fin = dot_q;
    na_fin  = na_q;
    nb_fin  = nb_q;
    ovf_fin = 1'b1;
    if (cnt_q < CntMax) begin
      dot_fin = dot_q + SumWidth'(p_ab);
      na_fin  = na_q + SumWidth'($unsigned(p_aa));
      nb_fin  = nb_q + SumWidth'($unsigned(p_bb));
      ovf_fin = 1'b0;
    end
  end

  // Finish stage registers.
  logic                 neg_q, ovf_q, zero_q;
  logic [SumWidth-1:0]  mag_q, fa_q, fb_q;
  logic [ProdWidth-1:0] prod_q;
  logic [1:0]           mstep_q;
  logic                 mdone_q;
  logic [15:0]          pp;

  // normA*normB as 16x48 partial products, one per cycle, top slice first.
  assign pp = fb_q[SumWidth-1 -: 16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mstep_q <= '0;
      mdone_q <= 1'b0;
    end else if (cmd_i.latch) begin
      mstep_q <= '0;
      mdone_q <= 1'b0;
    end else if (cmd_i.mul_step) begin
      mstep_q <= mstep_q + 1'b1;
      mdone_q <= (mstep_q == 2'd2);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      neg_q  <= dot_fin[SumWidth-1];
      mag_q  <= dot_fin[SumWidth-1] ? SumWidth'(-dot_fin) : SumWidth'(dot_fin);
      fa_q   <= na_fin;
      fb_q   <= nb_fin;
      zero_q <= (na_fin == '0) || (nb_fin == '0);
      ovf_q  <= ovf_fin;
      prod_q <= '0;
    end else if (cmd_i.mul_step) begin
      prod_q <= (prod_q << 16) + ProdWidth'(fa_q * pp);
      fb_q   <= fb_q << 16;
    end
  end

  // Bit-serial floor square root, two result bits per cycle.
  logic [RootWidth-1:0] root_q;
  logic [ProdWidth-1:0] rem_q, sq_q;
  logic [5:0]           sbit_q;
  logic                 sdone_q;
  logic [RootWidth-1:0] r1, r2, c2;
  logic [ProdWidth-1:0] rem1, rem2;

  function automatic logic [ProdWidth-1:0] r_ext(input logic [RootWidth-1:0] r);
    r_ext = ProdWidth'(r);
  endfunction

  // Remainder method: rem holds n - root^2 scaled; each bit tries 4r+1 at its weight.
  logic [ProdWidth+1:0] t1, t2;
  always_comb begin
    t1   = {rem_q, sq_q[ProdWidth-1 -: 2]} - {r_ext(root_q), 2'b01};
    r1   = t1[ProdWidth+1] ? {root_q[RootWidth-2:0], 1'b0} : {root_q[RootWidth-2:0], 1'b1};
    rem1 = t1[ProdWidth+1] ? {rem_q[ProdWidth-3:0], sq_q[ProdWidth-1 -: 2]} : t1[ProdWidth-1:0];
    t2   = {rem1, sq_q[ProdWidth-3 -: 2]} - {r_ext(r1), 2'b01};
    r2   = t2[ProdWidth+1] ? {r1[RootWidth-2:0], 1'b0} : {r1[RootWidth-2:0], 1'b1};
    rem2 = t2[ProdWidth+1] ? {rem1[ProdWidth-3:0], sq_q[ProdWidth-3 -: 2]} : t2[ProdWidth-1:0];
    c2   = r2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sbit_q  <= '0;
      sdone_q <= 1'b0;
    end else if (cmd_i.sqrt_init) begin
      sbit_q  <= '0;
      sdone_q <= 1'b0;
    end else if (cmd_i.sqrt_step) begin
      sbit_q  <= sbit_q + 1'b1;
      sdone_q <= (sbit_q == 6'd23);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_init) begin
      root_q <= '0;
      rem_q  <= '0;
      sq_q   <= prod_q;
    end else if (cmd_i.sqrt_step) begin
      root_q <= c2;
      rem_q  <= rem2;
      sq_q   <= sq_q << 4;
    end
  end

  // Restoring divider: (mag << 15) / root, one quotient bit per cycle.
  localparam int unsigned DivBits = SumWidth + 15;
  logic [DivBits-1:0]   dvd_q;
  logic [RootWidth:0]   drem_q;
  logic [6:0]           dcnt_q;
  logic                 ddone_q;
  logic [RootWidth+1:0] dtry;
  assign dtry = {drem_q, dvd_q[DivBits-1]} - {2'b00, root_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q  <= '0;
      ddone_q <= 1'b0;
    end else if (cmd_i.div_init) begin
      dcnt_q  <= '0;
      ddone_q <= 1'b0;
    end else if (cmd_i.div_step) begin
      dcnt_q  <= dcnt_q + 1'b1;
      ddone_q <= (dcnt_q == 7'(DivBits - 1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      dvd_q  <= {mag_q, 15'd0};
      drem_q <= '0;
    end else if (cmd_i.div_step) begin
      if (dtry[RootWidth+1]) begin
        drem_q <= {drem_q[RootWidth-1:0], dvd_q[DivBits-1]};
        dvd_q  <= {dvd_q[DivBits-2:0], 1'b0};
      end else begin
        drem_q <= dtry[RootWidth:0];
        dvd_q  <= {dvd_q[DivBits-2:0], 1'b1};
      end
    end
  end

  // Saturate the quotient (held in dvd_q) and register the result.
  logic signed [CosWidth-1:0] cos_q;
  logic                       zn_q, of_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.sat) begin
      zn_q <= zero_q;
      of_q <= ovf_q;
      if (zero_q) begin
        cos_q <= '0;
      end else if (neg_q) begin
        cos_q <= (dvd_q > DivBits'(32768)) ? 16'sh8000 : CosWidth'(-dvd_q);
      end else begin
        cos_q <= (dvd_q > DivBits'(32767)) ? 16'sh7FFF : CosWidth'(dvd_q);
      end
    end
  end

  assign cosine_o          = cos_q;
  assign zero_norm_o       = zn_q;
  assign overflow_o        = of_q;
  assign sts_o.zero_norm   = zero_q;
  assign sts_o.mul_done    = mdone_q;
  assign sts_o.sqrt_done   = sdone_q;
  assign sts_o.div_done    = ddone_q;

endmodule

/* dv/tb_cosine_similarity_stream.sv */
// Testbench for the streaming cosine similarity block.
// Depends on css_pkg, css_stream_if and cosine_similarity_stream.
`timescale 1ns / 1ps

// Tracks the exact running sums and holds the cosine results still owed.
class cosine_scoreboard;
  typedef struct {
    logic signed [15:0] cosine;
    logic               zero_norm;
    logic               overflow;
  } cos_result_t;

  localparam int unsigned MaxPairs = 65536;

  logic signed [47:0] dot_acc;
  logic [47:0]        norm_a_acc;
  logic [47:0]        norm_b_acc;
  int unsigned        pair_count;
  cos_result_t        pending_q[$];
  int unsigned        fail_count;

  function new();
    dot_acc    = '0;
    norm_a_acc = '0;
    norm_b_acc = '0;
    pair_count = 0;
    fail_count = 0;
  endfunction

  // Floor square root of a 96-bit product, one bit at a time.
  function automatic logic [47:0] floor_root(logic [95:0] n);
    logic [47:0] root;
    logic [47:0] cand;
    root = '0;
    for (int i = 47; i >= 0; i--) begin
      cand = root | (48'd1 << i);
      if (({48'd0, cand} * {48'd0, cand}) <= n) root = cand;
    end
    return root;
  endfunction

  // Notes an accepted element pair; a pair marked last owes one result.
  function void note_pair(logic signed [15:0] a, logic signed [15:0] b, logic last);
    cos_result_t exp_res;
    logic signed [47:0] ax;
    logic signed [47:0] bx;
    logic [95:0] prod;
    logic [47:0] denom;
    logic [63:0] mag;
    logic [63:0] quot;
    ax = a;
    bx = b;
    if (pair_count < MaxPairs) begin
      dot_acc    = dot_acc + ax * bx;
      norm_a_acc = norm_a_acc + 48'(ax * ax);
      norm_b_acc = norm_b_acc + 48'(bx * bx);
      pair_count++;
    end else begin
      pair_count = MaxPairs + 1;
    end
    if (!last) return;
    exp_res.cosine    = '0;
    exp_res.zero_norm = 1'b0;
    exp_res.overflow  = pair_count > MaxPairs;
    if (norm_a_acc == 0 || norm_b_acc == 0) begin
      exp_res.zero_norm = 1'b1;
    end else begin
      prod  = {48'd0, norm_a_acc} * {48'd0, norm_b_acc};
      denom = floor_root(prod);
      mag   = (dot_acc < 0) ? 64'(-dot_acc) : 64'(dot_acc);
      quot  = (mag << 15) / {16'd0, denom};
      if (dot_acc < 0)
        exp_res.cosine = (quot > 64'd32768) ? -16'sd32768 : 16'(-quot);
      else
        exp_res.cosine = (quot > 64'd32767) ? 16'sd32767 : 16'(quot);
    end
    pending_q.push_back(exp_res);
    dot_acc    = '0;
    norm_a_acc = '0;
    norm_b_acc = '0;
    pair_count = 0;
  endfunction

  // Compares an accepted result with the oldest one owed.
  function void check_result(logic signed [15:0] cosine, logic zero_norm, logic overflow);
    cos_result_t exp_res;
    if (pending_q.size() == 0) begin
      $display("%0t: unexpected result cosine=%0d zero_norm=%0b overflow=%0b",
               $time, cosine, zero_norm, overflow);
      fail_count++;
      return;
    end
    exp_res = pending_q.pop_front();
    if (cosine !== exp_res.cosine || zero_norm !== exp_res.zero_norm ||
        overflow !== exp_res.overflow) begin
      $display("%0t: mismatch expected cosine=%0d zero_norm=%0b overflow=%0b",
               $time, exp_res.cosine, exp_res.zero_norm, exp_res.overflow);
      $display("%0t:          actual   cosine=%0d zero_norm=%0b overflow=%0b",
               $time, cosine, zero_norm, overflow);
      fail_count++;
    end
  endfunction
endclass

module tb;
  import css_pkg::*;

  logic clk_i;
  logic rst_ni;
  int   send_idle_pct;
  int   recv_stall_pct;

  css_stream_if #(.Width(33)) in_if ();
  css_stream_if #(.Width(18)) out_if ();

  cosine_scoreboard cos_sb;

  cosine_similarity_stream uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  // Clock with a 12 ns period.
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Receiver: ready changes at the falling edge, stalling at random.
  always @(negedge clk_i) begin
    out_if.ready = rst_ni && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Monitor: sample both channels at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready)
      cos_sb.note_pair(in_if.data[15:0], in_if.data[31:16], in_if.data[32]);
    if (rst_ni && out_if.valid && out_if.ready)
      cos_sb.check_result(out_if.data[15:0], out_if.data[16], out_if.data[17]);
  end

  // Sends one element pair, with random idle cycles in front of it.
  task automatic send_pair(logic signed [15:0] a, logic signed [15:0] b, logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid = 1'b1;
    in_if.data  = {last, b, a};
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
    in_if.valid = 1'b0;
  endtask

  // Sends a random vector pair of the given length.
  task automatic send_random_vector(int unsigned len);
    logic signed [15:0] a;
    logic signed [15:0] b;
    int unsigned kind;
    kind = $urandom_range(0, 9);
    for (int unsigned i = 0; i < len; i++) begin
      a = 16'($urandom());
      b = 16'($urandom());
      if (kind == 0) b = a;                                 // parallel vectors
      else if (kind == 1) b = -a;                           // opposed vectors
      else if (kind == 2) a = 16'($urandom_range(0, 3) - 1); // tiny values
      else if (kind == 3 && $urandom_range(0, 3) != 0) b = '0;
      send_pair(a, b, i == len - 1);
    end
  endtask

  // Waits until every owed result has come, then for the finish latency.
  task automatic drain();
    while (cos_sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
  endtask

  initial begin
    cos_sb         = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_ni         = 1'b0;
    in_if.valid    = 1'b0;
    in_if.data     = '0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: extremes, zero norms, single elements and short vectors.
    send_pair(-16'sd32768, -16'sd32768, 1'b1);
    send_pair(-16'sd32768, 16'sd32767, 1'b1);
    send_pair(16'sd32767, 16'sd32767, 1'b1);
    send_pair(16'sd32767, -16'sd32768, 1'b1);
    send_pair(16'sd0, 16'sd0, 1'b1);
    send_pair(16'sd1234, 16'sd0, 1'b1);
    send_pair(16'sd0, -16'sd77, 1'b1);
    send_pair(16'sd1, 16'sd1, 1'b1);
    send_pair(16'sd1, -16'sd1, 1'b1);
    send_pair(16'sd3, 16'sd4, 1'b0);
    send_pair(16'sd4, -16'sd3, 1'b1);
    send_pair(16'sd1, 16'sd2, 1'b0);
    send_pair(16'sd2, 16'sd1, 1'b0);
    send_pair(16'sd3, 16'sd3, 1'b1);
    send_pair(-16'sd5, 16'sd9, 1'b0);
    send_pair(16'sd0, 16'sd0, 1'b1);
    drain();

    // Random vectors over the idling phases.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        3: begin send_idle_pct = 31; recv_stall_pct = 31; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int n = 0; n < 100; ) begin
        automatic int unsigned len = ($urandom_range(0, 9) == 0) ?
                                     $urandom_range(20, 40) : $urandom_range(1, 8);
        send_random_vector(len);
        n += len;
      end
    end
    drain();

    if (cos_sb.fail_count == 0 && cos_sb.pending_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Timeout far beyond the slowest correct run.
  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
